>>> rtl/pcxrle_pkg.sv
`timescale 1ns / 1ps

package pcxrle_pkg;

   localparam int REG_W  = 13;
   localparam int ADDR_W = 24;
   localparam int POS_W  = 12;
   localparam int RUN_W  = 6;
   localparam int IDX_W  = 2;

   localparam logic [1:0]       COUNT_MARK = 2'b11;
   localparam logic [RUN_W-1:0] RUN_MASK   = 6'h3F;

   localparam logic [IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [IDX_W-1:0] CSR_BUFFER_WIDTH  = 2'd2;
   localparam logic [IDX_W-1:0] CSR_BUFFER_HEIGHT = 2'd3;

   localparam logic [REG_W-1:0] RST_IMAGE_WIDTH   = 13'd320;
   localparam logic [REG_W-1:0] RST_IMAGE_HEIGHT  = 13'd200;
   localparam logic [REG_W-1:0] RST_BUFFER_WIDTH  = 13'd512;
   localparam logic [REG_W-1:0] RST_BUFFER_HEIGHT = 13'd512;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } pcxrle_state_type;

   typedef struct packed {
      logic accept;
      logic emit;
   } pcxrle_cmd_type;

   typedef struct packed {
      logic run_start;
      logic slot_free;
      logic final_pixel;
   } pcxrle_stat_type;

endpackage

>>> rtl/pcxrle_ctrl.sv
`timescale 1ns / 1ps

module pcxrle_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  pcxrle_pkg::pcxrle_stat_type stat,
   output pcxrle_pkg::pcxrle_cmd_type  cmd
);
   import pcxrle_pkg::*;

   pcxrle_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.emit   = 1'b0;
      req_stall  = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid && stat.run_start) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.emit = stat.slot_free;
            if (stat.slot_free && stat.final_pixel) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/pcxrle_dpath.sv
`timescale 1ns / 1ps

module pcxrle_dpath #(
   parameter int MAX_DIMENSION = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [pcxrle_pkg::IDX_W-1:0]    csr_index,
   input  logic [pcxrle_pkg::REG_W-1:0]    csr_wdata,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_start_image,
   input  logic                            rsp_stall,
   input  pcxrle_pkg::pcxrle_cmd_type      cmd,
   output pcxrle_pkg::pcxrle_stat_type     stat,
   output logic                            rsp_valid,
   output logic [7:0]                      rsp_pixel_value,
   output logic [pcxrle_pkg::POS_W-1:0]    rsp_x_pos,
   output logic [pcxrle_pkg::POS_W-1:0]    rsp_y_pos,
   output logic [pcxrle_pkg::ADDR_W-1:0]   rsp_write_address,
   output logic                            rsp_in_buffer,
   output logic                            rsp_last_of_run,
   output logic                            rsp_image_done
);
   import pcxrle_pkg::*;

   // dimension cap, saturated to what a register can hold
   localparam logic [REG_W-1:0] DIM_CAP =
      (MAX_DIMENSION >= (1 << REG_W) - 1) ? {REG_W{1'b1}} : REG_W'(MAX_DIMENSION);

   logic [REG_W-1:0]  img_w_ff, img_h_ff, buf_w_ff, buf_h_ff;
   logic [REG_W-1:0]  col_ff, col_in;
   logic [REG_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic              await_ff, await_in;
   logic [RUN_W-1:0]  pending_ff, pending_in;
   logic [RUN_W-1:0]  remain_ff, remain_in;
   logic [7:0]        value_ff, value_in;

   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_value_ff, out_value_in;
   logic [POS_W-1:0]  out_x_ff, out_x_in;
   logic [POS_W-1:0]  out_y_ff, out_y_in;
   logic [ADDR_W-1:0] out_addr_ff, out_addr_in;
   logic              out_inbuf_ff, out_inbuf_in;
   logic              out_last_ff, out_last_in;
   logic              out_done_ff, out_done_in;

   logic [REG_W-1:0]  w_eff, h_eff;
   logic [REG_W-1:0]  dec_col, dec_row;
   logic [ADDR_W-1:0] dec_base;
   logic              dec_await;
   logic [RUN_W-1:0]  dec_pending;
   logic              blocked, is_count;

   logic [REG_W-1:0]  col_next, row_next;
   logic              row_wrap, img_end, last_pix;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= RST_IMAGE_WIDTH;
         img_h_ff <= RST_IMAGE_HEIGHT;
         buf_w_ff <= RST_BUFFER_WIDTH;
         buf_h_ff <= RST_BUFFER_HEIGHT;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   img_w_ff <= csr_wdata;
            CSR_IMAGE_HEIGHT:  img_h_ff <= csr_wdata;
            CSR_BUFFER_WIDTH:  buf_w_ff <= csr_wdata;
            CSR_BUFFER_HEIGHT: buf_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign w_eff = (img_w_ff > DIM_CAP) ? DIM_CAP : img_w_ff;
   assign h_eff = (img_h_ff > DIM_CAP) ? DIM_CAP : img_h_ff;

   // byte decode, with position cleared first on a new image
   always_comb begin
      dec_col     = req_start_image ? '0 : col_ff;
      dec_row     = req_start_image ? '0 : row_ff;
      dec_base    = req_start_image ? '0 : base_ff;
      dec_await   = req_start_image ? 1'b0 : await_ff;
      dec_pending = req_start_image ? '0 : pending_ff;
      blocked     = (w_eff == '0) || (h_eff == '0) || (dec_row >= h_eff);
      is_count    = (req_data_byte[7:6] == COUNT_MARK);
   end

   // next pixel position
   always_comb begin
      col_next = col_ff + REG_W'(1);
      row_wrap = (col_next >= w_eff);
      row_next = row_wrap ? row_ff + REG_W'(1) : row_ff;
      img_end  = (row_next >= h_eff);
      last_pix = (remain_ff == RUN_W'(1)) || img_end;
   end

   assign stat.run_start   = !blocked && (dec_await ? (dec_pending != '0) : !is_count);
   assign stat.slot_free   = !out_valid_ff || !rsp_stall;
   assign stat.final_pixel = last_pix;

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      base_in    = base_ff;
      await_in   = await_ff;
      pending_in = pending_ff;
      remain_in  = remain_ff;
      value_in   = value_ff;

      out_valid_in = out_valid_ff && rsp_stall;
      out_value_in = out_value_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_addr_in  = out_addr_ff;
      out_inbuf_in = out_inbuf_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;

      if (cmd.accept) begin
         col_in     = dec_col;
         row_in     = dec_row;
         base_in    = dec_base;
         await_in   = dec_await;
         pending_in = dec_pending;
         if (!blocked) begin
            if (dec_await) begin
               await_in   = 1'b0;
               pending_in = '0;
               remain_in  = dec_pending;
               value_in   = req_data_byte;
            end else if (is_count) begin
               await_in   = 1'b1;
               pending_in = req_data_byte[RUN_W-1:0] & RUN_MASK;
            end else begin
               remain_in = RUN_W'(1);
               value_in  = req_data_byte;
            end
         end
      end

      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_value_in = value_ff;
         out_x_in     = col_ff[POS_W-1:0];
         out_y_in     = row_ff[POS_W-1:0];
         out_addr_in  = base_ff + ADDR_W'(col_ff);
         out_inbuf_in = (col_ff < buf_w_ff) && (row_ff < buf_h_ff);
         out_last_in  = last_pix;
         out_done_in  = img_end;
         remain_in    = remain_ff - RUN_W'(1);
         col_in       = row_wrap ? '0 : col_next;
         row_in       = row_next;
         base_in      = row_wrap ? base_ff + ADDR_W'(buf_w_ff) : base_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         base_ff      <= '0;
         await_ff     <= 1'b0;
         pending_ff   <= '0;
         remain_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         base_ff      <= base_in;
         await_ff     <= await_in;
         pending_ff   <= pending_in;
         remain_ff    <= remain_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      out_value_ff <= out_value_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_addr_ff  <= out_addr_in;
      out_inbuf_ff <= out_inbuf_in;
      out_last_ff  <= out_last_in;
      out_done_ff  <= out_done_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pixel_value   = out_value_ff;
   assign rsp_x_pos         = out_x_ff;
   assign rsp_y_pos         = out_y_ff;
   assign rsp_write_address = out_addr_ff;
   assign rsp_in_buffer     = out_inbuf_ff;
   assign rsp_last_of_run   = out_last_ff;
   assign rsp_image_done    = out_done_ff;

endmodule

>>> rtl/pcx_rle_pixel_decoder_unit.sv
`timescale 1ns / 1ps

// channel | direction | beat
// req     | in        | one compressed byte plus start_image flag
// rsp     | out       | one decoded pixel with position, address and flags
// csr     | in        | register write, index 0..3, no read-back
//
// A byte is taken while no run is being emitted; a literal gives one pixel, a
// count byte only sets the pending run, and its value byte gives up to n pixels.
// The run counter emits one pixel per cycle into the output register while rsp_stall is low.
// rsp_stall holds the run; req_stall is high while a run is being emitted.
// Reset loads the default dimensions and clears position and pending run.
module pcx_rle_pixel_decoder_unit #(
   parameter int MAX_DIMENSION = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [pcxrle_pkg::IDX_W-1:0]  csr_index,
   input  logic [pcxrle_pkg::REG_W-1:0]  csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_start_image,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_pixel_value,
   output logic [pcxrle_pkg::POS_W-1:0]  rsp_x_pos,
   output logic [pcxrle_pkg::POS_W-1:0]  rsp_y_pos,
   output logic [pcxrle_pkg::ADDR_W-1:0] rsp_write_address,
   output logic                          rsp_in_buffer,
   output logic                          rsp_last_of_run,
   output logic                          rsp_image_done
);
   import pcxrle_pkg::*;

   pcxrle_cmd_type  cmd;
   pcxrle_stat_type stat;

   pcxrle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pcxrle_dpath #(
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_data_byte     (req_data_byte),
      .req_start_image   (req_start_image),
      .rsp_stall         (rsp_stall),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_x_pos         (rsp_x_pos),
      .rsp_y_pos         (rsp_y_pos),
      .rsp_write_address (rsp_write_address),
      .rsp_in_buffer     (rsp_in_buffer),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_image_done    (rsp_image_done)
   );

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_done |-> rsp_last_of_run)
      else $error("image_done without last_of_run");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run |=> rsp_valid)
      else $error("run gap after a taken pixel");

   a_input_held_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> req_stall)
      else $error("byte taken while a run is open");

endmodule
